/* hdl/qec_pkg.sv */
`timescale 1ns / 1ps

package qec_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_PIN_CHANGE = 2'd0,
    KIND_RESET      = 2'd1,
    KIND_HOME       = 2'd2
  } kind_e;

  // Register index of the direction control
  localparam int unsigned REG_INVERT_DIRECTION = 0;

  // Reported widths
  localparam int unsigned OUT_WIDTH  = 32;
  localparam int unsigned EDGE_WIDTH = 32;
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 3;

  // Step codes
  localparam logic signed [1:0] STEP_ZERO = 2'sb00;
  localparam logic signed [1:0] STEP_FWD  = 2'sb01;
  localparam logic signed [1:0] STEP_BWD  = 2'sb11;

  typedef struct packed {
    logic [1:0] kind;
    logic       edge_on_a;
    logic       pin_a;
    logic       pin_b;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0]            step;
    logic signed [OUT_WIDTH-1:0]  position;
    logic signed [OUT_WIDTH-1:0]  home_position;
    logic [EDGE_WIDTH-1:0]        edges_a;
    logic [EDGE_WIDTH-1:0]        edges_b;
  } out_item_t;

  // Previous phase in the upper two index bits, current phase in the lower two
  function automatic logic signed [1:0] phase_step(input logic [1:0] prev_phase,
                                                   input logic [1:0] cur_phase);
    logic [3:0] idx;
    logic signed [1:0] s;
    idx = {prev_phase, cur_phase};
    case (idx)
      4'b0001, 4'b0111, 4'b1110, 4'b1000: s = STEP_FWD;
      4'b0010, 4'b0100, 4'b1101, 4'b1011: s = STEP_BWD;
      default:                            s = STEP_ZERO;
    endcase
    return s;
  endfunction

endpackage

/* hdl/qec_core.sv */
`timescale 1ns / 1ps

// Counter state: decodes one item and updates the counters when it advances.
// Both the plain and the negated form of each position count are kept so that
// the reported value needs no second adder after the step add.
module qec_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  qec_pkg::in_item_t      item_i,
  output logic signed [1:0]      step_o,
  output logic [COUNT_WIDTH-1:0] work_o,
  output logic [COUNT_WIDTH-1:0] work_neg_o,
  output logic [COUNT_WIDTH-1:0] home_o,
  output logic [COUNT_WIDTH-1:0] home_neg_o,
  output logic [qec_pkg::EDGE_WIDTH-1:0] edges_a_o,
  output logic [qec_pkg::EDGE_WIDTH-1:0] edges_b_o
);
  import qec_pkg::*;

  logic [COUNT_WIDTH-1:0] work_q, work_d, work_neg_q, work_neg_d;
  logic [COUNT_WIDTH-1:0] home_q, home_d, home_neg_q, home_neg_d;
  logic [EDGE_WIDTH-1:0]  edges_a_q, edges_a_d, edges_b_q, edges_b_d;
  logic [1:0]             phase_q, phase_d;
  logic [1:0]             cur_phase;
  logic signed [1:0]      step;
  logic [COUNT_WIDTH-1:0] step_ext;

  assign cur_phase = {item_i.pin_a, item_i.pin_b};
  assign step_ext  = {{(COUNT_WIDTH-2){step[1]}}, step};

  // Next state for this item
  always_comb begin
    step       = STEP_ZERO;
    work_d     = work_q;
    work_neg_d = work_neg_q;
    home_d     = home_q;
    home_neg_d = home_neg_q;
    edges_a_d  = edges_a_q;
    edges_b_d  = edges_b_q;
    phase_d    = phase_q;
    case (item_i.kind)
      KIND_PIN_CHANGE: begin
        step       = phase_step(phase_q, cur_phase);
        work_d     = work_q + step_ext;
        work_neg_d = work_neg_q - step_ext;
        home_d     = home_q + step_ext;
        home_neg_d = home_neg_q - step_ext;
        if (item_i.edge_on_a) begin
          edges_a_d = edges_a_q + 1'b1;
        end else begin
          edges_b_d = edges_b_q + 1'b1;
        end
        phase_d = cur_phase;
      end
      KIND_RESET: begin
        work_d     = '0;
        work_neg_d = '0;
        edges_a_d  = '0;
        edges_b_d  = '0;
        phase_d    = cur_phase;
      end
      KIND_HOME: begin
        work_d     = '0;
        work_neg_d = '0;
        home_d     = '0;
        home_neg_d = '0;
        phase_d    = cur_phase;
      end
      default: ; // unused kind leaves everything as is
    endcase
  end

  // State registers, updated only when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q     <= '0;
      work_neg_q <= '0;
      home_q     <= '0;
      home_neg_q <= '0;
      edges_a_q  <= '0;
      edges_b_q  <= '0;
      phase_q    <= '0;
    end else if (adv_i) begin
      work_q     <= work_d;
      work_neg_q <= work_neg_d;
      home_q     <= home_d;
      home_neg_q <= home_neg_d;
      edges_a_q  <= edges_a_d;
      edges_b_q  <= edges_b_d;
      phase_q    <= phase_d;
    end
  end

  assign step_o     = step;
  assign work_o     = work_d;
  assign work_neg_o = work_neg_d;
  assign home_o     = home_d;
  assign home_neg_o = home_neg_d;
  assign edges_a_o  = edges_a_d;
  assign edges_b_o  = edges_b_d;

endmodule

/* hdl/qec_report.sv */
`timescale 1ns / 1ps

// Picks the plain or negated count and fits it to the 32-bit report width.
module qec_report #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic [COUNT_WIDTH-1:0]               cnt_i,
  input  logic [COUNT_WIDTH-1:0]               cnt_neg_i,
  input  logic                                 invert_i,
  output logic signed [qec_pkg::OUT_WIDTH-1:0] pos_o
);
  import qec_pkg::*;

  logic [COUNT_WIDTH-1:0] sel;

  assign sel = invert_i ? cnt_neg_i : cnt_i;

  // Narrow counts are sign-extended, wide ones keep their low bits
  if (COUNT_WIDTH >= OUT_WIDTH) begin : g_trunc
    assign pos_o = sel[OUT_WIDTH-1:0];
  end else begin : g_sext
    assign pos_o = {{(OUT_WIDTH-COUNT_WIDTH){sel[COUNT_WIDTH-1]}}, sel};
  end

endmodule

/* hdl/quadrature_encoder_counter_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_item_i  (qec_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i out_item_o (qec_pkg::out_item_t)
// cfg       input      APB write/read            invert_direction at byte address 0
//
// One item per cycle while the output is not stalled: an item is held in the input register,
// is decoded and counted by the step add, and is then registered in the result register.
// Reset clears all counters and the phase to zero; invert_direction resets to 1.
// A stalled output holds its result; the input register still takes one more
// item, and in_stall_o rises only when both registers are full.
module quadrature_encoder_counter_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  qec_pkg::in_item_t                       in_item_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output qec_pkg::out_item_t                      out_item_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [qec_pkg::APB_ADDR_WIDTH-1:0]      paddr,
  input  logic [qec_pkg::APB_DATA_WIDTH-1:0]      pwdata,
  output logic [qec_pkg::APB_DATA_WIDTH-1:0]      prdata,
  output logic                                    pready
);
  import qec_pkg::*;

  logic                   in_vld_q, in_vld_d;
  in_item_t               in_q;
  logic                   out_vld_q, out_vld_d;
  out_item_t              out_q, res;
  logic                   adv;
  logic                   invert_q;
  logic                   reg_hit;
  logic signed [1:0]      step;
  logic [COUNT_WIDTH-1:0] work, work_neg, home, home_neg;
  logic [EDGE_WIDTH-1:0]  edges_a, edges_b;

  // Pipeline control
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_vld_d   = in_stall_o ? in_vld_q : in_valid_i;
  assign out_vld_d  = adv ? 1'b1 : (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_q <= in_item_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  // Configuration register
  assign reg_hit = (paddr[APB_ADDR_WIDTH-1:2] == REG_INVERT_DIRECTION[APB_ADDR_WIDTH-3:0]);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(APB_DATA_WIDTH-1){1'b0}}, invert_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      invert_q <= pwdata[0];
    end
  end

  qec_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .item_i     (in_q),
    .step_o     (step),
    .work_o     (work),
    .work_neg_o (work_neg),
    .home_o     (home),
    .home_neg_o (home_neg),
    .edges_a_o  (edges_a),
    .edges_b_o  (edges_b)
  );

  qec_report #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_rep_work (
    .cnt_i     (work),
    .cnt_neg_i (work_neg),
    .invert_i  (invert_q),
    .pos_o     (res.position)
  );

  qec_report #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_rep_home (
    .cnt_i     (home),
    .cnt_neg_i (home_neg),
    .invert_i  (invert_q),
    .pos_o     (res.home_position)
  );

  assign res.step    = step;
  assign res.edges_a = edges_a;
  assign res.edges_b = edges_b;

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/qec_checker.sv */
`timescale 1ns / 1ps

// Port-level checks for the quadrature counter
module qec_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input qec_pkg::out_item_t out_item_o
);
  import qec_pkg::*;

  // A held result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A held result does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  // Input backpressure only comes from a full, stalled result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side free");

  // The step code is never the unused value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.step != 2'sb10)
    else $error("illegal step code");

endmodule

bind quadrature_encoder_counter_unit qec_checker u_qec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* verif/tb_quadrature_encoder_counter_unit.sv */
`timescale 1ns / 1ps

module tb_quadrature_encoder_counter_unit;
  import qec_pkg::*;

  // kind code the block leaves undecoded
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned WALK_ITEMS = 550;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_item_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  // expected counter state, advanced on each accepted transfer
  logic [31:0] work_cnt;
  logic [31:0] home_cnt;
  logic [31:0] edges_a_cnt;
  logic [31:0] edges_b_cnt;
  logic [1:0] prev_phase;
  logic invert_setting;

  out_item_t count_reports[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic steady_flow;

  quadrature_encoder_counter_unit u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // rank of a phase along the forward cycle 00, 01, 11, 10 (self-inverse map)
  function automatic logic [1:0] quad_rank(input logic [1:0] p);
    return {p[1], p[1] ^ p[0]};
  endfunction

  // apply one item to the expected state and form its report
  function automatic out_item_t advance_count(input in_item_t it);
    out_item_t r;
    logic [1:0] ph;
    logic [1:0] rank_diff;
    ph = {it.pin_a, it.pin_b};
    r.step = STEP_ZERO;
    case (it.kind)
      KIND_PIN_CHANGE: begin
        if (it.edge_on_a) edges_a_cnt = edges_a_cnt + 1;
        else edges_b_cnt = edges_b_cnt + 1;
        rank_diff = quad_rank(ph) - quad_rank(prev_phase);
        // one phase ahead counts up, one behind counts down, else no step
        if (rank_diff == 2'd1) begin
          r.step = STEP_FWD;
          work_cnt = work_cnt + 1;
          home_cnt = home_cnt + 1;
        end else if (rank_diff == 2'd3) begin
          r.step = STEP_BWD;
          work_cnt = work_cnt - 1;
          home_cnt = home_cnt - 1;
        end
        prev_phase = ph;
      end
      KIND_RESET: begin
        work_cnt = '0;
        edges_a_cnt = '0;
        edges_b_cnt = '0;
        prev_phase = ph;
      end
      KIND_HOME: begin
        work_cnt = '0;
        home_cnt = '0;
        prev_phase = ph;
      end
      default: ;
    endcase
    r.position = invert_setting ? -work_cnt : work_cnt;
    r.home_position = invert_setting ? -home_cnt : home_cnt;
    r.edges_a = edges_a_cnt;
    r.edges_b = edges_b_cnt;
    return r;
  endfunction

  // one input transfer, with random gaps ahead of it
  task automatic send_item(input logic [1:0] kind, input logic on_a, input logic a,
                           input logic b);
    in_item_t it;
    it = '{kind: kind, edge_on_a: on_a, pin_a: a, pin_b: b};
    while (!steady_flow && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    count_reports.push_back(advance_count(it));
  endtask

  // stop sending and wait for every pending report
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (count_reports.size() != 0);
  endtask

  // APB write of the direction register: setup, then access
  task automatic set_direction(input logic inv);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_WIDTH'(REG_INVERT_DIRECTION * 4);
    pwdata <= {{(APB_DATA_WIDTH-1){1'b0}}, inv};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    invert_setting = inv;
  endtask

  // full forward cycle, then full backward cycle, from phase 00
  task automatic test_step_decode();
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b0, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b1, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b1, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b0, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b1, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b1, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b0, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b0, 1'b0);
  endtask

  // no phase change and jumps across two phases give no step, mixed with one forward step
  task automatic test_invalid_transitions();
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b0, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b1, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b0, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b0, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b1, 1'b0);
  endtask

  // reset and home items resample the phase; the unused kind keeps it
  task automatic test_clear_items();
    send_item(KIND_RESET, 1'b1, 1'b1, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b1, 1'b0);
    send_item(KIND_HOME, 1'b0, 1'b0, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b1, 1'b1);
    send_item(KIND_UNUSED, 1'b1, 1'b0, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b1, 1'b0);
  endtask

  // plain and inverted reporting
  task automatic test_direction_setting();
    drain_results();
    set_direction(1'b0);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b0, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b0, 1'b1);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b1, 1'b1);
    drain_results();
    set_direction(1'b1);
    send_item(KIND_PIN_CHANGE, 1'b0, 1'b1, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b0, 1'b0);
    send_item(KIND_PIN_CHANGE, 1'b1, 1'b1, 1'b0);
  endtask

  // mostly clean quadrature walk with direction changes, some clears and noise
  task automatic test_random_walk(input int unsigned n);
    logic [1:0] rank;
    logic [1:0] nxt;
    int unsigned pick;
    logic fwd;
    fwd = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      steady_flow = (i >= 150 && i < 300);
      if (i == 275 || i == 450) begin
        drain_results();
        set_direction(i == 275 ? 1'b0 : 1'b1);
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(9) == 0) fwd = !fwd;
        rank = quad_rank(prev_phase);
        rank = fwd ? rank + 2'd1 : rank - 2'd1;
        nxt = quad_rank(rank);
        send_item(KIND_PIN_CHANGE, nxt[1] != prev_phase[1], nxt[1], nxt[0]);
      end else if (pick < 85) begin
        send_item(KIND_RESET, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (pick < 90) begin
        send_item(KIND_HOME, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (pick < 93) begin
        send_item(KIND_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
    end
    steady_flow = 1'b0;
  endtask

  // result side: random stall, compare each transfer with the oldest report
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (count_reports.size() == 0) begin
          $error("result transfer with no expected report");
          errors++;
        end else begin
          want = count_reports.pop_front();
          if (out_item_o.step !== want.step) begin
            $error("step: expected %0d, got %0d", want.step, out_item_o.step);
            errors++;
          end
          if (out_item_o.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_item_o.position);
            errors++;
          end
          if (out_item_o.home_position !== want.home_position) begin
            $error("home_position: expected %0d, got %0d", want.home_position,
                   out_item_o.home_position);
            errors++;
          end
          if (out_item_o.edges_a !== want.edges_a) begin
            $error("edges_a: expected %0d, got %0d", want.edges_a, out_item_o.edges_a);
            errors++;
          end
          if (out_item_o.edges_b !== want.edges_b) begin
            $error("edges_b: expected %0d, got %0d", want.edges_b, out_item_o.edges_b);
            errors++;
          end
        end
      end
      out_stall_i <= steady_flow ? 1'b0 : ($urandom_range(99) < 34);
    end
  end

  initial begin
    steady_flow = 1'b0;
    work_cnt = '0;
    home_cnt = '0;
    edges_a_cnt = '0;
    edges_b_cnt = '0;
    prev_phase = 2'b00;
    invert_setting = 1'b1;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_step_decode();
    test_invalid_transitions();
    test_clear_items();
    test_direction_setting();
    test_random_walk(WALK_ITEMS);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
